>>> hw/rtl/pbcp_pkg.sv
`timescale 1ns / 1ps

package pbcp_pkg;

  // Command word decode masks and patterns
  localparam logic [31:0] OLD_JUMP_MASK   = 32'he000_0003;
  localparam logic [31:0] OLD_JUMP_MATCH  = 32'h2000_0000;
  localparam logic [31:0] OLD_JUMP_TARGET = 32'h1fff_ffff;
  localparam logic [31:0] ADDR_MASK       = 32'hffff_fffc;
  localparam logic [31:0] RETURN_WORD     = 32'h0002_0000;
  localparam logic [31:0] HEADER_MASK     = 32'he003_0003;
  localparam logic [31:0] INC_HDR_MATCH   = 32'h0000_0000;
  localparam logic [31:0] NONINC_HDR_MATCH = 32'h4000_0000;
  localparam logic [1:0]  TAG_JUMP        = 2'd1;
  localparam logic [1:0]  TAG_CALL        = 2'd2;
  localparam logic [31:0] FETCH_LIMIT_RST = 32'hffff_ffff;
  localparam logic [31:0] WORD_BYTES      = 32'd4;

  localparam int unsigned METHOD_W = 11;
  localparam int unsigned SUBCH_W  = 3;
  localparam int unsigned COUNT_W  = 11;

  // Queue between decode and execute
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CMD_OLD_JUMP,
    CMD_JUMP,
    CMD_CALL,
    CMD_RETURN,
    CMD_INC_HDR,
    CMD_NONINC_HDR,
    CMD_RESERVED
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_PROTECTION = 3'd1,
    ERR_CALL       = 3'd2,
    ERR_RETURN     = 3'd3,
    ERR_RESERVED   = 3'd4
  } err_e;

  typedef enum logic {
    FUNC_WORD   = 1'b0,
    FUNC_RESUME = 1'b1
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [31:0] word;
    logic [31:0] addr;
    logic        prot;
    cmd_e        cmd;
  } item_t;

endpackage

>>> hw/rtl/pbcp_front.sv
`timescale 1ns / 1ps

module pbcp_front import pbcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        func_i,
  input  logic [31:0] word_i,
  input  logic [31:0] word_address_i,
  output item_t       item_o
);

  logic [31:0] fetch_limit_q;
  logic [31:0] addr;
  cmd_e        cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fetch_limit_q <= FETCH_LIMIT_RST;
    end else if (cfg_valid_i) begin
      fetch_limit_q <= cfg_data_i;
    end
  end

  assign addr = word_address_i & ADDR_MASK;

  // Classify the word as a command; run state decides later whether it is data
  always_comb begin
    if ((word_i & OLD_JUMP_MASK) == OLD_JUMP_MATCH) begin
      cmd = CMD_OLD_JUMP;
    end else if (word_i[1:0] == TAG_JUMP) begin
      cmd = CMD_JUMP;
    end else if (word_i[1:0] == TAG_CALL) begin
      cmd = CMD_CALL;
    end else if (word_i == RETURN_WORD) begin
      cmd = CMD_RETURN;
    end else if ((word_i & HEADER_MASK) == INC_HDR_MATCH) begin
      cmd = CMD_INC_HDR;
    end else if ((word_i & HEADER_MASK) == NONINC_HDR_MATCH) begin
      cmd = CMD_NONINC_HDR;
    end else begin
      cmd = CMD_RESERVED;
    end
  end

  assign item_o.func = func_i ? FUNC_RESUME : FUNC_WORD;
  assign item_o.word = word_i;
  assign item_o.addr = addr;
  assign item_o.prot = (addr >= fetch_limit_q);
  assign item_o.cmd  = cmd;

endmodule

>>> hw/rtl/pbcp_queue.sv
`timescale 1ns / 1ps

module pbcp_queue import pbcp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t pop_data_o
);

  item_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
    logic [QPTR_W-1:0] res;
    if (ptr == QPTR_W'(QDEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + 1'b1;
    end
    return res;
  endfunction

  assign full_o     = (count_q == QCNT_W'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/pbcp_back.sv
`timescale 1ns / 1ps

module pbcp_back import pbcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  item_t               item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                push_valid_o,
  output logic [METHOD_W-1:0] method_address_o,
  output logic [SUBCH_W-1:0]  subchannel_o,
  output logic                nonincrementing_o,
  output logic [31:0]         data_o,
  output logic [31:0]         next_address_o,
  output logic [2:0]          error_code_o,
  output logic                suspended_o,
  output logic [COUNT_W-1:0]  data_count_o
);

  // Architectural state
  logic [31:0]         ret_addr_q, ret_addr_d;
  logic                in_sub_q, in_sub_d;
  logic [METHOD_W-1:0] run_method_q, run_method_d;
  logic [SUBCH_W-1:0]  run_subch_q, run_subch_d;
  logic [COUNT_W-1:0]  run_remaining_q, run_remaining_d;
  logic                run_noninc_q, run_noninc_d;
  logic [COUNT_W-1:0]  run_count_q, run_count_d;
  err_e                err_q, err_d;
  logic                halted_q, halted_d;

  // Output register
  logic                out_valid_q;
  logic                pv_q, pv_d;
  logic [METHOD_W-1:0] method_q, method_d;
  logic [SUBCH_W-1:0]  subch_q, subch_d;
  logic                noninc_q, noninc_d;
  logic [31:0]         data_q, data_d;
  logic [31:0]         next_q, next_d;

  logic [31:0]         get_addr;

  assign pop_o    = !empty_i && (!out_valid_q || !out_stall_i);
  assign get_addr = item_i.addr + WORD_BYTES;

  always_comb begin
    ret_addr_d      = ret_addr_q;
    in_sub_d        = in_sub_q;
    run_method_d    = run_method_q;
    run_subch_d     = run_subch_q;
    run_remaining_d = run_remaining_q;
    run_noninc_d    = run_noninc_q;
    run_count_d     = run_count_q;
    err_d           = err_q;
    halted_d        = halted_q;
    pv_d            = 1'b0;
    method_d        = '0;
    subch_d         = '0;
    noninc_d        = 1'b0;
    data_d          = '0;
    next_d          = item_i.addr;

    if (item_i.func == FUNC_RESUME) begin
      err_d    = ERR_NONE;
      halted_d = 1'b0;
    end else if (!halted_q) begin
      if (item_i.prot) begin
        err_d    = ERR_PROTECTION;
        halted_d = 1'b1;
      end else if (run_remaining_q != '0) begin
        // Data word of the current run
        pv_d     = 1'b1;
        method_d = run_method_q;
        subch_d  = run_subch_q;
        noninc_d = run_noninc_q;
        data_d   = item_i.word;
        if (!run_noninc_q) begin
          run_method_d = run_method_q + 1'b1;
        end
        run_remaining_d = run_remaining_q - 1'b1;
        run_count_d     = run_count_q + 1'b1;
        next_d          = get_addr;
      end else begin
        case (item_i.cmd)
          CMD_OLD_JUMP: begin
            next_d = item_i.word & OLD_JUMP_TARGET;
          end
          CMD_JUMP: begin
            next_d = item_i.word & ADDR_MASK;
          end
          CMD_CALL: begin
            if (in_sub_q) begin
              err_d    = ERR_CALL;
              halted_d = 1'b1;
            end else begin
              ret_addr_d = get_addr;
              in_sub_d   = 1'b1;
              next_d     = item_i.word & ADDR_MASK;
            end
          end
          CMD_RETURN: begin
            if (!in_sub_q) begin
              err_d    = ERR_RETURN;
              halted_d = 1'b1;
              next_d   = get_addr;
            end else begin
              next_d   = ret_addr_q & ADDR_MASK;
              in_sub_d = 1'b0;
            end
          end
          CMD_INC_HDR, CMD_NONINC_HDR: begin
            run_method_d    = item_i.word[12:2];
            run_subch_d     = item_i.word[15:13];
            run_remaining_d = item_i.word[28:18];
            run_noninc_d    = (item_i.cmd == CMD_NONINC_HDR);
            run_count_d     = '0;
            next_d          = get_addr;
          end
          default: begin
            err_d    = ERR_RESERVED;
            halted_d = 1'b1;
            next_d   = get_addr;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_addr_q      <= '0;
      in_sub_q        <= 1'b0;
      run_method_q    <= '0;
      run_subch_q     <= '0;
      run_remaining_q <= '0;
      run_noninc_q    <= 1'b0;
      run_count_q     <= '0;
      err_q           <= ERR_NONE;
      halted_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        ret_addr_q      <= ret_addr_d;
        in_sub_q        <= in_sub_d;
        run_method_q    <= run_method_d;
        run_subch_q     <= run_subch_d;
        run_remaining_q <= run_remaining_d;
        run_noninc_q    <= run_noninc_d;
        run_count_q     <= run_count_d;
        err_q           <= err_d;
        halted_q        <= halted_d;
        out_valid_q     <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pv_q     <= pv_d;
      method_q <= method_d;
      subch_q  <= subch_d;
      noninc_q <= noninc_d;
      data_q   <= data_d;
      next_q   <= next_d;
    end
  end

  // Status fields show the state committed with the held transaction
  assign out_valid_o       = out_valid_q;
  assign push_valid_o      = pv_q;
  assign method_address_o  = method_q;
  assign subchannel_o      = subch_q;
  assign nonincrementing_o = noninc_q;
  assign data_o            = data_q;
  assign next_address_o    = next_q;
  assign error_code_o      = err_q;
  assign suspended_o       = halted_q;
  assign data_count_o      = run_count_q;

endmodule

>>> hw/rtl/pushbuffer_command_parser.sv
`timescale 1ns / 1ps
// An accepted transaction is queued, then executed and held in the output register.
// Throughput: one transaction per cycle while out_stall is low, set by the execute
// stage and its output register; a two-entry queue between decode and execute absorbs
// output stalls. Reset: asynchronous, active low; clears run, subroutine and error state,
// empties the queue and sets fetch_limit to all ones.

module pushbuffer_command_parser import pbcp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         fetch_limit_i,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func_i,
  input  logic [31:0]         word_i,
  input  logic [31:0]         word_address_i,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                push_valid_o,
  output logic [METHOD_W-1:0] method_address_o,
  output logic [SUBCH_W-1:0]  subchannel_o,
  output logic                nonincrementing_o,
  output logic [31:0]         data_o,
  output logic [31:0]         next_address_o,
  output logic [2:0]          error_code_o,
  output logic                suspended_o,
  output logic [COUNT_W-1:0]  data_count_o
);

  item_t dec_item;
  item_t head_item;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  assign in_stall = q_full;

  pbcp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (fetch_limit_i),
    .func_i         (func_i),
    .word_i         (word_i),
    .word_address_i (word_address_i),
    .item_o         (dec_item)
  );

  pbcp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid && !q_full),
    .push_data_i (dec_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (head_item)
  );

  pbcp_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (q_empty),
    .item_i            (head_item),
    .pop_o             (q_pop),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .push_valid_o      (push_valid_o),
    .method_address_o  (method_address_o),
    .subchannel_o      (subchannel_o),
    .nonincrementing_o (nonincrementing_o),
    .data_o            (data_o),
    .next_address_o    (next_address_o),
    .error_code_o      (error_code_o),
    .suspended_o       (suspended_o),
    .data_count_o      (data_count_o)
  );

endmodule

>>> verif/tb_pushbuffer_command_parser.sv
`timescale 1ns / 1ps

module tb_pushbuffer_command_parser;
  import pbcp_pkg::*;

  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic                push_valid;
    logic [METHOD_W-1:0] method_address;
    logic [SUBCH_W-1:0]  subchannel;
    logic                nonincrementing;
    logic [31:0]         data;
    logic [31:0]         next_address;
    logic [2:0]          error_code;
    logic                suspended;
    logic [COUNT_W-1:0]  data_count;
  } entry_t;

  class parser_scoreboard;
    logic [31:0]         fetch_limit;
    logic [31:0]         return_addr;
    bit                  in_subroutine;
    logic [METHOD_W-1:0] run_method;
    logic [SUBCH_W-1:0]  run_subch;
    logic [COUNT_W-1:0]  run_left;
    bit                  run_noninc;
    logic [COUNT_W-1:0]  run_count;
    err_e                err_state;
    bit                  halted;
    logic [31:0]         last_next;
    entry_t              expected_entries[$];
    int                  errors;

    function new();
      fetch_limit   = FETCH_LIMIT_RST;
      return_addr   = '0;
      in_subroutine = 1'b0;
      run_method    = '0;
      run_subch     = '0;
      run_left      = '0;
      run_noninc    = 1'b0;
      run_count     = '0;
      err_state     = ERR_NONE;
      halted        = 1'b0;
      last_next     = '0;
      errors        = 0;
    endfunction

    function void latch_error(err_e code);
      err_state = code;
      halted    = 1'b1;
    endfunction

    function void open_run(logic [31:0] w, bit noninc);
      run_method = w[12:2];
      run_subch  = w[15:13];
      run_left   = w[28:18];
      run_noninc = noninc;
      run_count  = '0;
    endfunction

    // Decode one accepted transaction and queue the entry it must produce
    function void decode_word(func_e f, logic [31:0] w, logic [31:0] addr_in);
      entry_t      e;
      logic [31:0] addr;
      logic [31:0] nxt;
      logic [31:0] step_addr;
      e         = '0;
      addr      = addr_in & ADDR_MASK;
      nxt       = addr;
      step_addr = addr + WORD_BYTES;
      if (f == FUNC_RESUME) begin
        err_state = ERR_NONE;
        halted    = 1'b0;
      end else if (!halted) begin
        if (addr >= fetch_limit) begin
          latch_error(ERR_PROTECTION);
        end else if (run_left != 0) begin
          e.push_valid      = 1'b1;
          e.method_address  = run_method;
          e.subchannel      = run_subch;
          e.nonincrementing = run_noninc;
          e.data            = w;
          if (!run_noninc) run_method = run_method + 1'b1;
          run_left  = run_left - 1'b1;
          run_count = run_count + 1'b1;
          nxt       = step_addr;
        end else if ((w & OLD_JUMP_MASK) == OLD_JUMP_MATCH) begin
          nxt = w & OLD_JUMP_TARGET;
        end else if (w[1:0] == TAG_JUMP) begin
          nxt = w & ADDR_MASK;
        end else if (w[1:0] == TAG_CALL) begin
          if (in_subroutine) begin
            latch_error(ERR_CALL);
          end else begin
            return_addr   = step_addr;
            in_subroutine = 1'b1;
            nxt           = w & ADDR_MASK;
          end
        end else if (w == RETURN_WORD) begin
          if (!in_subroutine) begin
            latch_error(ERR_RETURN);
            nxt = step_addr;
          end else begin
            nxt           = return_addr & ADDR_MASK;
            in_subroutine = 1'b0;
          end
        end else if ((w & HEADER_MASK) == INC_HDR_MATCH) begin
          open_run(w, 1'b0);
          nxt = step_addr;
        end else if ((w & HEADER_MASK) == NONINC_HDR_MATCH) begin
          open_run(w, 1'b1);
          nxt = step_addr;
        end else begin
          latch_error(ERR_RESERVED);
          nxt = step_addr;
        end
      end
      e.next_address = nxt;
      e.error_code   = err_state;
      e.suspended    = halted;
      e.data_count   = run_count;
      last_next      = nxt;
      expected_entries.push_back(e);
    endfunction

    function string describe(entry_t e);
      return $sformatf("pv=%0b m=%03h sc=%0d ni=%0b data=%08h next=%08h err=%0d susp=%0b cnt=%0d",
                       e.push_valid, e.method_address, e.subchannel, e.nonincrementing,
                       e.data, e.next_address, e.error_code, e.suspended, e.data_count);
    endfunction

    function void check_entry(entry_t got);
      entry_t x;
      if (expected_entries.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", describe(got));
        return;
      end
      x = expected_entries.pop_front();
      if (got.push_valid !== x.push_valid || got.method_address !== x.method_address ||
          got.subchannel !== x.subchannel || got.nonincrementing !== x.nonincrementing ||
          got.data !== x.data || got.next_address !== x.next_address ||
          got.error_code !== x.error_code || got.suspended !== x.suspended ||
          got.data_count !== x.data_count) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  expected %s", describe(x));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [31:0]         fetch_limit_i  = FETCH_LIMIT_RST;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                func_i         = 1'b0;
  logic [31:0]         word_i         = '0;
  logic [31:0]         word_address_i = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic                push_valid_o;
  logic [METHOD_W-1:0] method_address_o;
  logic [SUBCH_W-1:0]  subchannel_o;
  logic                nonincrementing_o;
  logic [31:0]         data_o;
  logic [31:0]         next_address_o;
  logic [2:0]          error_code_o;
  logic                suspended_o;
  logic [COUNT_W-1:0]  data_count_o;

  parser_scoreboard sb = new();

  int          burst_left   = 0;
  int          stall_mode   = 0;
  int          stall_left   = 0;
  int unsigned stall_phase  = 0;
  int          idle_cycles  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pushbuffer_command_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .fetch_limit_i     (fetch_limit_i),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .func_i            (func_i),
    .word_i            (word_i),
    .word_address_i    (word_address_i),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .push_valid_o      (push_valid_o),
    .method_address_o  (method_address_o),
    .subchannel_o      (subchannel_o),
    .nonincrementing_o (nonincrementing_o),
    .data_o            (data_o),
    .next_address_o    (next_address_o),
    .error_code_o      (error_code_o),
    .suspended_o       (suspended_o),
    .data_count_o      (data_count_o)
  );

  // Receiver back-pressure: switch between free-running, random, periodic and heavy stall
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 150);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_stall = 1'b0;
      1: out_stall = ($urandom_range(0, 99) < 35);
      2: out_stall = (stall_phase % 3 == 0);
      default: out_stall = ($urandom_range(0, 99) < 80);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall)
        sb.check_entry({push_valid_o, method_address_o, subchannel_o, nonincrementing_o,
                        data_o, next_address_o, error_code_o, suspended_o, data_count_o});
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL pushbuffer_command_parser");
        $finish;
      end
    end
  end

  function automatic logic [31:0] header_word(bit noninc, logic [COUNT_W-1:0] cnt,
                                              logic [SUBCH_W-1:0] sc, logic [METHOD_W-1:0] m);
    return {1'b0, noninc, 1'b0, cnt, 2'b00, sc, m, 2'b00};
  endfunction

  function automatic logic [COUNT_W-1:0] run_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return COUNT_W'($urandom_range(1, 6));
    if (r < 95) return COUNT_W'($urandom_range(7, 40));
    return COUNT_W'($urandom_range(41, 120));
  endfunction

  function automatic logic [31:0] below_limit();
    if (sb.fetch_limit == 0) return $urandom & ADDR_MASK;
    return $urandom_range(0, sb.fetch_limit - 1) & ADDR_MASK;
  endfunction

  // Follow the predicted fetch address; stray outside it now and then
  function automatic logic [31:0] pick_address();
    if ($urandom_range(0, 39) == 0) return $urandom & ADDR_MASK;
    if (sb.last_next < sb.fetch_limit) return sb.last_next;
    return below_limit();
  endfunction

  function automatic void next_stream_item(output func_e f, output logic [31:0] w,
                                           output logic [31:0] a);
    int r;
    f = FUNC_WORD;
    w = $urandom;
    a = pick_address();
    r = $urandom_range(0, 99);
    if (sb.halted) begin
      if (r < 85) f = FUNC_RESUME;
    end else if (sb.run_left != 0) begin
      if (r < 3) f = FUNC_RESUME;
    end else if (r < 30) begin
      w = header_word(1'b0, run_length(), SUBCH_W'($urandom_range(0, 7)),
                      METHOD_W'($urandom_range(0, 2047)));
    end else if (r < 50) begin
      w = header_word(1'b1, run_length(), SUBCH_W'($urandom_range(0, 7)),
                      METHOD_W'($urandom_range(0, 2047)));
    end else if (r < 60) begin
      w = below_limit() | TAG_JUMP;
    end else if (r < 65) begin
      w = OLD_JUMP_MATCH | (below_limit() & OLD_JUMP_TARGET);
    end else if (r < 80) begin
      // mostly balanced call/return pairs, sometimes nested or stray
      if (sb.in_subroutine == (r < 78)) w = RETURN_WORD;
      else w = below_limit() | TAG_CALL;
    end else if (r < 85) begin
      w[1:0] = 2'b11;
    end else if (r < 90) begin
      w[1:0] = 2'b00;
      w[31]  = 1'b1;
    end else if (r >= 97) begin
      f = FUNC_RESUME;
    end
  endfunction

  task automatic send_item(func_e f, logic [31:0] w, logic [31:0] a);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8) : $urandom_range(20, 80);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid       = 1'b1;
    func_i         = f;
    word_i         = w;
    word_address_i = a;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sb.decode_word(f, w, a);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_fetch_limit(logic [31:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_valid     = 1'b1;
    fetch_limit_i = v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    sb.fetch_limit = v;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic run_random(int n);
    func_e       f;
    logic [31:0] w;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      next_stream_item(f, w, a);
      send_item(f, w, a);
      // hold off until the block is empty now and then
      if (i % 200 == 199) drain_results();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_fetch_limit(FETCH_LIMIT_RST);
    send_item(FUNC_RESUME, 32'hdead_beef, 32'h0000_0000);
    send_item(FUNC_WORD, header_word(1'b0, 11'd3, 3'd7, 11'h7ff), 32'h0000_0000);
    send_item(FUNC_WORD, 32'h0000_0000, 32'h0000_0004);
    send_item(FUNC_WORD, 32'hffff_ffff, 32'h0000_0008);
    send_item(FUNC_WORD, 32'h5a5a_5a5a, 32'h0000_000c);
    send_item(FUNC_WORD, header_word(1'b1, 11'd2, 3'd5, 11'h123), 32'h0000_0010);
    send_item(FUNC_WORD, 32'ha5a5_a5a5, 32'h0000_0014);
    send_item(FUNC_WORD, 32'h1234_5678, 32'h0000_0018);
    send_item(FUNC_WORD, header_word(1'b0, 11'd0, 3'd2, 11'h005), 32'h0000_001c);
    send_item(FUNC_WORD, 32'hffff_fff8 | TAG_JUMP, 32'h0000_0020);
    // fetch address wraps past the top of memory
    send_item(FUNC_WORD, header_word(1'b0, 11'd1, 3'd1, 11'h004), 32'hffff_fff8);
    send_item(FUNC_WORD, 32'h8000_0001, 32'hffff_fffc);
    send_item(FUNC_WORD, 32'h3fff_fffc, 32'h0000_0000);
    send_item(FUNC_WORD, 32'h0000_1000 | TAG_CALL, 32'h1fff_fffc);
    send_item(FUNC_WORD, 32'h0000_2000 | TAG_CALL, 32'h0000_1000);
    send_item(FUNC_WORD, RETURN_WORD, 32'h0000_1000);
    send_item(FUNC_RESUME, 32'h0000_0000, 32'h0000_1000);
    send_item(FUNC_WORD, RETURN_WORD, 32'h0000_1000);
    send_item(FUNC_WORD, RETURN_WORD, 32'h2000_0000);
    send_item(FUNC_RESUME, 32'hffff_ffff, 32'h2000_0004);
    send_item(FUNC_WORD, 32'hffff_ffff, 32'h2000_0004);
    send_item(FUNC_RESUME, 32'h0000_0000, 32'h2000_0008);
    run_random(400);

    write_fetch_limit(32'h0000_4000);
    send_item(FUNC_WORD, 32'h0000_0000 | TAG_JUMP, 32'h0000_4000);
    send_item(FUNC_WORD, 32'h0000_0100 | TAG_JUMP, 32'h0000_4000);
    send_item(FUNC_RESUME, 32'h0000_0000, 32'h0000_3ffc);
    run_random(300);

    write_fetch_limit(32'h0000_0000);
    run_random(30);
    write_fetch_limit(32'h8000_0000);
    run_random(250);
    write_fetch_limit($urandom);
    run_random(250);
    write_fetch_limit(FETCH_LIMIT_RST);
    run_random(200);

    drain_results();
    repeat (5) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("PASS pushbuffer_command_parser");
    else
      $display("FAIL pushbuffer_command_parser");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pbcp_pkg.sv
hw/rtl/pbcp_front.sv
hw/rtl/pbcp_queue.sv
hw/rtl/pbcp_back.sv
hw/rtl/pushbuffer_command_parser.sv
verif/tb_pushbuffer_command_parser.sv
